FILE: hdl/mcat_pkg.sv
package mcat_pkg;

   // element geometry
   localparam int unsigned DIM    = 4;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned IDX_W  = 4;
   localparam int unsigned RC_W   = 2;

   // request function codes
   localparam logic FUNC_LOAD_OP   = 1'b0;
   localparam logic FUNC_WRITE_CUR = 1'b1;

   // last element position of the product
   localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic             wr_cur;
      logic             wr_op;
      logic             issue;
      logic [IDX_W-1:0] issue_idx;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic advance;
      logic pipe_busy;
   } status_type;

endpackage

FILE: hdl/matrix_concatenate_4x4.sv
// sequence: an operand load with is_last starts the product; each element passes the issue,
//   multiply and output registers. throughput: one element load or overwrite per cycle
//   while idle; product elements leave at one per cycle through a four-lane multiply
//   pipeline unless the output stalls; requests wait until all sixteen have drained
// reset: synchronous; current matrix returns to identity, operand matrix is left as is
module matrix_concatenate_4x4 #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [mcat_pkg::IDX_W-1:0]         req_element_index,
   input  logic signed [mcat_pkg::DATA_W-1:0] req_element_value,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mcat_pkg::IDX_W-1:0]         rsp_result_index,
   output logic signed [mcat_pkg::DATA_W-1:0] rsp_result_value,
   output logic                               rsp_last,
   output logic                               rsp_saturated
);

   mcat_pkg::cmd_type    cmd;
   mcat_pkg::status_type stat;

   // sequencer
   mcat_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_is_last (req_is_last),
      .stat        (stat),
      .cmd         (cmd)
   );

   // matrices and multiply pipeline
   mcat_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_value  (rsp_result_value),
      .rsp_last          (rsp_last),
      .rsp_saturated     (rsp_saturated)
   );

   // a multiply request closes the request side at once
   a_busy_after_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == mcat_pkg::FUNC_LOAD_OP) && req_is_last)
      |=> !req_ready)
      else $error("request accepted during multiply");

   // requests are taken only with an empty multiply pipeline
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.pipe_busy)
      else $error("request side open while pipeline busy");

   // a clamped element holds one of the range limits
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
      ((rsp_result_value == 32'sh7FFF_FFFF) || (rsp_result_value == 32'sh8000_0000)))
      else $error("saturated element not at a limit");

   // no new product element while the output is full and stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !stat.advance)
      else $error("pipeline advanced into a stalled output");

endmodule

FILE: hdl/mcat_ctrl.sv
module mcat_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic                 req_is_last,
   input  mcat_pkg::status_type stat,
   output mcat_pkg::cmd_type    cmd
);

   mcat_pkg::ctrl_state_type state_ff, state_in;
   logic [mcat_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic                       accept;

   assign req_ready = (state_ff == mcat_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // element writes from accepted requests
   assign cmd.wr_cur    = accept && (req_func == mcat_pkg::FUNC_WRITE_CUR);
   assign cmd.wr_op     = accept && (req_func == mcat_pkg::FUNC_LOAD_OP);
   assign cmd.issue     = (state_ff == mcat_pkg::ST_ISSUE) && stat.advance;
   assign cmd.issue_idx = cnt_ff;

   // sequencer for the sixteen product elements
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         mcat_pkg::ST_IDLE: begin
            if (cmd.wr_op && req_is_last) begin
               state_in = mcat_pkg::ST_ISSUE;
               cnt_in   = '0;
            end
         end
         mcat_pkg::ST_ISSUE: begin
            if (cmd.issue) begin
               cnt_in = cnt_ff + mcat_pkg::IDX_W'(1);
               if (cnt_ff == mcat_pkg::LAST_IDX) begin
                  state_in = mcat_pkg::ST_DRAIN;
               end
            end
         end
         mcat_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = mcat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcat_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcat_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: hdl/mcat_dpath.sv
module mcat_dpath #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mcat_pkg::cmd_type                 cmd,
   output mcat_pkg::status_type              stat,
   input  logic [mcat_pkg::IDX_W-1:0]        req_element_index,
   input  logic signed [mcat_pkg::DATA_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mcat_pkg::IDX_W-1:0]        rsp_result_index,
   output logic signed [mcat_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_last,
   output logic                              rsp_saturated
);

   localparam int unsigned DW    = mcat_pkg::DATA_W;
   localparam int unsigned SH_W  = 2 * DW - FRAC_BITS;
   localparam int unsigned SUM_W = SH_W + 2;
   localparam int unsigned TOP_W = SUM_W - DW + 1;
   localparam logic [DW-1:0] ONE_VAL = DW'(64'd1 << FRAC_BITS);
   localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

   // current matrix by row, operand matrix by column
   logic signed [DW-1:0] cur_ff [mcat_pkg::DIM][mcat_pkg::DIM];
   logic signed [DW-1:0] op_ff  [mcat_pkg::DIM][mcat_pkg::DIM];

   // pipeline registers
   logic signed [DW-1:0]   row_ff  [mcat_pkg::DIM];
   logic signed [DW-1:0]   col_ff  [mcat_pkg::DIM];
   logic signed [SH_W-1:0] prod_ff [mcat_pkg::DIM];
   logic [mcat_pkg::IDX_W-1:0] idx1_ff, idx2_ff, oidx_ff;
   logic v1_ff, v1_in, v2_ff, v2_in, ov_ff, ov_in;
   logic signed [DW-1:0] oval_ff;
   logic                 osat_ff;

   logic                   advance;
   logic [mcat_pkg::RC_W-1:0] in_row, in_col, is_row, is_col, wb_row, wb_col;
   logic signed [2*DW-1:0] full_prod [mcat_pkg::DIM];
   logic signed [SUM_W-1:0] sum;
   logic [TOP_W-1:0]        top;
   logic                    ovf;
   logic signed [DW-1:0]    sat_val;

   assign advance        = !ov_ff || rsp_ready;
   assign stat.advance   = advance;
   assign stat.pipe_busy = v1_ff || v2_ff;

   assign in_row = req_element_index[3:2];
   assign in_col = req_element_index[1:0];
   assign is_row = cmd.issue_idx[3:2];
   assign is_col = cmd.issue_idx[1:0];
   assign wb_row = idx2_ff[3:2];
   assign wb_col = idx2_ff[1:0];

   // pipeline valid flags, frozen while the output is stalled
   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      ov_in = ov_ff;
      if (advance) begin
         v1_in = cmd.issue;
         v2_in = v1_ff;
         ov_in = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         ov_ff <= ov_in;
      end
   end

   // full-width signed products of the four lanes
   always_comb begin
      for (int k = 0; k < mcat_pkg::DIM; k++) begin
         full_prod[k] = $signed({{DW{row_ff[k][DW-1]}}, row_ff[k]})
                      * $signed({{DW{col_ff[k][DW-1]}}, col_ff[k]});
      end
   end

   // sum of four shifted products and clamp to 32 bits
   always_comb begin
      sum = '0;
      for (int k = 0; k < mcat_pkg::DIM; k++) begin
         sum = sum + SUM_W'(prod_ff[k]);
      end
      top     = sum[SUM_W-1:DW-1];
      ovf     = !((&top) || (~|top));
      sat_val = sum[SUM_W-1] ? $signed(MIN_VAL) : $signed(MAX_VAL);
   end

   // current matrix: identity on reset, element writes and product write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mcat_pkg::DIM; r++) begin
            for (int c = 0; c < mcat_pkg::DIM; c++) begin
               cur_ff[r][c] <= (r == c) ? $signed(ONE_VAL) : '0;
            end
         end
      end else if (cmd.wr_cur) begin
         cur_ff[in_row][in_col] <= req_element_value;
      end else if (advance && v2_ff) begin
         cur_ff[wb_row][wb_col] <= ovf ? sat_val : sum[DW-1:0];
      end
   end

   // operand matrix, column-major storage
   always_ff @(posedge clock) begin
      if (cmd.wr_op) begin
         op_ff[in_col][in_row] <= req_element_value;
      end
   end

   // issue stage: row kept for a whole product row, column per element
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         col_ff  <= op_ff[is_col];
         idx1_ff <= cmd.issue_idx;
         if (is_col == '0) begin
            row_ff <= cur_ff[is_row];
         end
      end
   end

   // multiply stage, four lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < mcat_pkg::DIM; k++) begin
            prod_ff[k] <= SH_W'(full_prod[k] >>> FRAC_BITS);
         end
         idx2_ff <= idx1_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance && v2_ff) begin
         oidx_ff <= idx2_ff;
         oval_ff <= ovf ? sat_val : sum[DW-1:0];
         osat_ff <= ovf;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_index = oidx_ff;
   assign rsp_result_value = oval_ff;
   assign rsp_last         = (oidx_ff == mcat_pkg::LAST_IDX);
   assign rsp_saturated    = osat_ff;

endmodule
